[hw/rtl/swm_pkg.sv]
// shared constants of the sliding window minimum block
`default_nettype none

package swm_pkg;

	// largest window the candidate store can hold
	localparam int unsigned WINDOW_MAX_DEF = 1024;

	// width of a sample and of a minimum
	localparam int unsigned VAL_W = 32;

	// width of the window size register
	localparam int unsigned CFG_W = 11;

	// depth of the item queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

[hw/rtl/sliding_window_minimum.sv]
// top level of the streaming sliding window minimum
`default_nettype none

// Streaming sliding-window minimum over signed 32-bit samples. Write window_size
// (0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX) only while the block is
// idle; a new size applies from the next sample. Until window_size samples have
// arrived no result is given; after that each sample gives one result, the minimum
// of the last window_size samples. Samples enter a two-item queue and are taken by
// the back end when it is idle. The back end keeps a monotonic candidate queue in
// a single-port ring memory of WINDOW_MAX entries; for each sample it expires old
// candidates from the front, removes larger candidates from the back and then
// appends the sample. While a result is held by result_stall the next result-giving
// sample waits in the append step. Each candidate is removed at most once. The
// memory needs no clearing after reset.
module sliding_window_minimum #(
	parameter int unsigned WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              window_size_we,
	input  wire logic [swm_pkg::CFG_W-1:0]         window_size,
	input  wire logic                              sample_valid,
	output logic                                   sample_stall,
	input  wire logic signed [swm_pkg::VAL_W-1:0]  sample_value,
	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output logic signed [swm_pkg::VAL_W-1:0]       window_min
);
	import swm_pkg::*;

	localparam int unsigned PW = $clog2(2 * WINDOW_MAX);
	localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
	localparam int unsigned QW = VAL_W + PW + CW + 1;

	logic             push;
	logic [VAL_W-1:0] push_value;
	logic [PW-1:0]    push_pos;
	logic [CW-1:0]    push_win;
	logic             push_emit;
	logic             queue_full;
	logic             queue_valid;
	logic             queue_pop;
	logic [QW-1:0]    queue_data;

	swm_front #(
		.WINDOW_MAX (WINDOW_MAX),
		.PW         (PW),
		.CW         (CW)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.window_size_we (window_size_we),
		.window_size    (window_size),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample_value   (sample_value),
		.queue_full     (queue_full),
		.push           (push),
		.push_value     (push_value),
		.push_pos       (push_pos),
		.push_win       (push_win),
		.push_emit      (push_emit)
	);

	swm_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_value, push_pos, push_win, push_emit}),
		.full      (queue_full),
		.pop       (queue_pop),
		.not_empty (queue_valid),
		.pop_data  (queue_data)
	);

	swm_back #(
		.WINDOW_MAX (WINDOW_MAX),
		.PW         (PW),
		.CW         (CW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (queue_valid),
		.item_pop     (queue_pop),
		.item_value   (queue_data[QW-1 -: VAL_W]),
		.item_pos     (queue_data[CW+PW : CW+1]),
		.item_win     (queue_data[CW:1]),
		.item_emit    (queue_data[0]),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.window_min   (window_min)
	);

endmodule

`default_nettype wire

[hw/rtl/swm_front.sv]
// front end: window register, sample position and warm-up tracking
`default_nettype none

module swm_front #(
	parameter int unsigned WINDOW_MAX = 1024,
	parameter int unsigned PW = $clog2(2 * WINDOW_MAX),
	parameter int unsigned CW = $clog2(WINDOW_MAX + 1)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                window_size_we,
	input  wire logic [swm_pkg::CFG_W-1:0]           window_size,
	input  wire logic                                sample_valid,
	output logic                                     sample_stall,
	input  wire logic signed [swm_pkg::VAL_W-1:0]    sample_value,
	input  wire logic                                queue_full,
	output logic                                     push,
	output logic [swm_pkg::VAL_W-1:0]                push_value,
	output logic [PW-1:0]                            push_pos,
	output logic [CW-1:0]                            push_win,
	output logic                                     push_emit
);
	import swm_pkg::*;

	localparam int unsigned POS_MOD = 2 * WINDOW_MAX;

	logic [CFG_W-1:0] window_size_q;
	logic [PW-1:0]    pos_q;
	logic [CW-1:0]    seen_q;
	logic [CW-1:0]    seen_next;
	logic [CW-1:0]    win_eff;
	logic [PW-1:0]    pos_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= CFG_W'(1);
		end else if (window_size_we) begin
			window_size_q <= window_size;
		end
	end

	// zero acts as one, anything above the store size is clipped
	always_comb begin
		if (window_size_q == '0) begin
			win_eff = CW'(1);
		end else if (32'(window_size_q) > 32'(WINDOW_MAX)) begin
			win_eff = CW'(WINDOW_MAX);
		end else begin
			win_eff = CW'(window_size_q);
		end
	end

	assign seen_next = (seen_q < CW'(WINDOW_MAX)) ? seen_q + CW'(1) : seen_q;
	assign pos_next  = (pos_q == PW'(POS_MOD - 1)) ? '0 : pos_q + PW'(1);

	assign sample_stall = queue_full;
	assign push         = sample_valid && !queue_full;
	assign push_value   = sample_value;
	assign push_pos     = pos_q;
	assign push_win     = win_eff;
	assign push_emit    = (seen_next >= win_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			seen_q <= '0;
		end else if (push) begin
			pos_q  <= pos_next;
			seen_q <= seen_next;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/swm_queue.sv]
// short item queue between front end and back end
`default_nettype none

module swm_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output logic [WIDTH-1:0]      pop_data
);
	import swm_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign full      = (fill_q == CNT_W'(DEPTH));
	assign not_empty = (fill_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/swm_back.sv]
// back end: monotonic candidate queue in a ring memory and result register
`default_nettype none

module swm_back #(
	parameter int unsigned WINDOW_MAX = 1024,
	parameter int unsigned PW = $clog2(2 * WINDOW_MAX),
	parameter int unsigned CW = $clog2(WINDOW_MAX + 1)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                item_valid,
	output logic                                     item_pop,
	input  wire logic [swm_pkg::VAL_W-1:0]           item_value,
	input  wire logic [PW-1:0]                       item_pos,
	input  wire logic [CW-1:0]                       item_win,
	input  wire logic                                item_emit,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic signed [swm_pkg::VAL_W-1:0]         window_min
);
	import swm_pkg::*;

	localparam int unsigned AW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int unsigned POS_MOD = 2 * WINDOW_MAX;
	localparam int unsigned EW      = VAL_W + PW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXP  = 3'd1;
	localparam logic [2:0] S_EXPC = 3'd2;
	localparam logic [2:0] S_POP  = 3'd3;
	localparam logic [2:0] S_POPC = 3'd4;
	localparam logic [2:0] S_APP  = 3'd5;

	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
		input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (AW+1)'(WINDOW_MAX)) begin
			sum = sum - (AW+1)'(WINDOW_MAX);
		end
		return sum[AW-1:0];
	endfunction

	logic [EW-1:0]    mem [WINDOW_MAX];
	logic [EW-1:0]    rd_q;
	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [AW-1:0]    head_q;
	logic [CW-1:0]    count_q;
	logic             result_valid_q;
	logic [VAL_W-1:0] window_min_q;
	logic [VAL_W-1:0] head_val_q;
	logic [VAL_W-1:0] item_v_q;
	logic [PW-1:0]    item_pos_q;
	logic [CW-1:0]    item_win_q;
	logic             item_emit_q;

	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic [VAL_W-1:0] rd_value;
	logic [PW-1:0]    rd_pos;
	logic [PW:0]      age;
	logic             expire;
	logic             drop;
	logic             app_go;
	logic             can_store;

	assign rd_value = rd_q[EW-1:PW];
	assign rd_pos   = rd_q[PW-1:0];

	// age of the front entry relative to the new sample, modulo the position range
	always_comb begin
		if (item_pos_q >= rd_pos) begin
			age = {1'b0, item_pos_q} - {1'b0, rd_pos};
		end else begin
			age = {1'b0, item_pos_q} + (PW+1)'(POS_MOD) - {1'b0, rd_pos};
		end
	end

	assign expire    = (age >= (PW+1)'(item_win_q));
	assign drop      = ($signed(rd_value) > $signed(item_v_q));
	assign can_store = (count_q < CW'(WINDOW_MAX));
	assign app_go    = (state_q == S_APP)
		&& (!item_emit_q || !result_valid_q || !result_stall);
	assign item_pop  = (state_q == S_IDLE) && item_valid;
	assign wr_addr   = ring_add(head_q, AW'(count_q));

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		if (state_q == S_EXP) begin
			rd_en = (count_q != '0);
		end else if (state_q == S_POP) begin
			rd_en   = (count_q != '0);
			rd_addr = ring_add(head_q, AW'(count_q - CW'(1)));
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (item_valid) state_d = S_EXP;
			S_EXP:  state_d = (count_q != '0) ? S_EXPC : S_POP;
			S_EXPC: state_d = expire ? S_EXP : S_POP;
			S_POP:  state_d = (count_q != '0) ? S_POPC : S_APP;
			S_POPC: state_d = drop ? S_POP : S_APP;
			S_APP:  if (app_go) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (app_go && can_store) begin
			mem[wr_addr] <= {item_v_q, item_pos_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			head_q         <= '0;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_EXPC && expire) begin
				head_q  <= ring_add(head_q, AW'(1));
				count_q <= count_q - CW'(1);
			end else if (state_q == S_POPC && drop) begin
				count_q <= count_q - CW'(1);
			end else if (app_go && can_store) begin
				count_q <= count_q + CW'(1);
			end
			if (app_go && item_emit_q) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			item_v_q    <= item_value;
			item_pos_q  <= item_pos;
			item_win_q  <= item_win;
			item_emit_q <= item_emit;
		end
		// the first surviving front entry is the minimum unless the queue empties
		if (state_q == S_EXPC && !expire) begin
			head_val_q <= rd_value;
		end
		if (app_go && item_emit_q) begin
			window_min_q <= (count_q == '0) ? item_v_q : head_val_q;
		end
	end

	assign result_valid = result_valid_q;
	assign window_min   = window_min_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(WINDOW_MAX))
		else $error("candidate count beyond store size");

	a_result_from_append: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q) == S_APP)
		else $error("result raised outside the append step");

	a_pop_starts_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |=> state_q == S_EXP)
		else $error("item taken without starting expiry");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_stall |=> result_valid_q && $stable(window_min_q))
		else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
